/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/lkv_pkg.sv */
`default_nettype none

package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W  = IDX_W;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CAP_W-1:0]  cap_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic signed [VAL_W-1:0] val_t;

	localparam cap_t CAP_RESET = 5'd16;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_STORE  = 1'b1;

	// slot selection for the item in flight
	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		idx_t free_idx;
		idx_t lru_idx;
		logic room;
	} sel_t;

endpackage

`default_nettype wire

/* hw/rtl/lkv_match.sv */
`default_nettype none

module lkv_match
	import lkv_pkg::*;
(
	input  wire logic [ENTRIES-1:0] valid,
	input  wire key_t               keys [ENTRIES],
	input  wire rank_t              ranks [ENTRIES],
	input  wire cnt_t               occ,
	input  wire cap_t               capacity,
	input  wire key_t               key,
	output sel_t                    sel
);

	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;

	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// scan downwards so the lowest-numbered slot wins
	always_comb begin
		sel = '0;
		sel.room = CMP_W'(occ) < eff_cap;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid[i] && keys[i] == key) begin
				sel.hit     = 1'b1;
				sel.hit_idx = idx_t'(i);
			end
			if (!valid[i]) begin
				sel.free_idx = idx_t'(i);
			end
			// valid ranks are distinct 0..occ-1, so the oldest holds occ-1
			if (valid[i] && cnt_t'(ranks[i]) == occ - cnt_t'(1)) begin
				sel.lru_idx = idx_t'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lkv_store.sv */
`default_nettype none

module lkv_store
	import lkv_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic               mode,
	input  wire key_t               key,
	input  wire val_t               value,
	input  wire sel_t               sel,
	output logic [ENTRIES-1:0]      valid,
	output key_t                    keys [ENTRIES],
	output val_t                    values [ENTRIES],
	output rank_t                   ranks [ENTRIES],
	output cnt_t                    occ
);

	`include "assert_macros.svh"

	logic [ENTRIES-1:0] valid_q;
	key_t               keys_q [ENTRIES];
	val_t               values_q [ENTRIES];
	rank_t              ranks_q [ENTRIES];
	cnt_t               occ_q;

	logic apply;
	idx_t slot;
	cnt_t pivot;

	assign apply = advance && (mode == MODE_STORE || sel.hit);

	// a fill ages every valid entry, which is the same as pivoting on occ
	always_comb begin
		if (sel.hit) begin
			slot  = sel.hit_idx;
			pivot = cnt_t'(ranks_q[sel.hit_idx]);
		end else if (sel.room) begin
			slot  = sel.free_idx;
			pivot = occ_q;
		end else begin
			slot  = sel.lru_idx;
			pivot = cnt_t'(ranks_q[sel.lru_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				ranks_q[i] <= '0;
			end
		end else if (apply) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && idx_t'(i) != slot && cnt_t'(ranks_q[i]) < pivot) begin
					ranks_q[i] <= ranks_q[i] + 1'b1;
				end
			end
			ranks_q[slot] <= '0;
			valid_q[slot] <= 1'b1;
			if (mode == MODE_STORE && !sel.hit && sel.room) begin
				occ_q <= occ_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply && mode == MODE_STORE) begin
			values_q[slot] <= value;
			if (!sel.hit) begin
				keys_q[slot] <= key;
			end
		end
	end

	assign valid  = valid_q;
	assign keys   = keys_q;
	assign values = values_q;
	assign ranks  = ranks_q;
	assign occ    = occ_q;

	`ASSERT_ALWAYS(a_occ_count, occ_q == CNT_W'($countones(valid_q)), "occupancy out of step")
	`ASSERT_ALWAYS(a_occ_max, occ_q <= CNT_W'(ENTRIES), "occupancy above entry count")
	`ASSERT_NEXT(a_mru, apply, valid_q[$past(slot)] && ranks_q[$past(slot)] == '0, "touched slot not most recent")

endmodule

`default_nettype wire

/* hw/rtl/lru_key_value_cache_top.sv */
// Fully associative key-value cache, 16 entries, least recently used replacement.
// Input channel s_*: one item per lookup (tuser 0) or store (tuser 1); tdata carries
// key in bits 31:0 and value in bits 63:32. Output channel m_*: exactly one result
// per item, in order; tuser is found, tdata the value read (zero unless a lookup hit).
// Configuration channel cfg_*: writes the capacity register (5 bits), always ready;
// write it only while no item is in flight. Capacity 0 acts as 1, above 16 as 16.
// An item is registered on acceptance; its result is registered once the item leaves
// the input register, which needs a free result register. Throughput is one item per
// cycle while the receiver does not stall: key compare, slot choice and recency
// update all happen combinationally between the input and result registers.
// Reset empties the cache and sets capacity to 16; no clearing sweep is needed.
// When the receiver stalls the result register holds, the input register fills, and
// s_tready drops until the result is taken.

`default_nettype none

module lru_key_value_cache_top
	import lkv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // key[31:0], value[63:32]
	input  wire logic        s_tuser,   // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // read_value[31:0]
	output logic             m_tuser,   // found
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data   // capacity
);

	`include "assert_macros.svh"

	logic  s1_valid_q;
	logic  mode_s1;
	key_t  key_s1;
	val_t  value_s1;
	logic  m_valid_q;
	logic  found_q;
	val_t  rdata_q;
	cap_t  cap_q;

	logic               out_free;
	logic               advance;
	sel_t               sel;
	logic [ENTRIES-1:0] valid;
	key_t               keys [ENTRIES];
	val_t               values [ENTRIES];
	rank_t              ranks [ENTRIES];
	cnt_t               occ;

	assign out_free  = !m_valid_q || m_tready;
	assign advance   = s1_valid_q && out_free;
	assign s_tready  = !s1_valid_q || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			cap_q      <= CAP_RESET;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (out_free) begin
				m_valid_q <= advance;
			end
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= s_tuser;
			key_s1   <= s_tdata[31:0];
			value_s1 <= s_tdata[63:32];
		end
		if (advance) begin
			found_q <= sel.hit;
			rdata_q <= (mode_s1 == MODE_LOOKUP && sel.hit) ? values[sel.hit_idx] : '0;
		end
	end

	lkv_match u_match (
		.valid    (valid),
		.keys     (keys),
		.ranks    (ranks),
		.occ      (occ),
		.capacity (cap_q),
		.key      (key_s1),
		.sel      (sel)
	);

	lkv_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.mode    (mode_s1),
		.key     (key_s1),
		.value   (value_s1),
		.sel     (sel),
		.valid   (valid),
		.keys    (keys),
		.values  (values),
		.ranks   (ranks),
		.occ     (occ)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = rdata_q;
	assign m_tuser  = found_q;

	`ASSERT_NEXT(a_result, advance, m_valid_q, "item processed but no result shown")
	`ASSERT_IMPL(a_stall, !s_tready, s1_valid_q && m_valid_q && !m_tready, "input stalled without cause")

endmodule

`default_nettype wire

/* tb/sv/lru_key_value_cache_checker.sv */
`timescale 1ns / 100ps

module lru_key_value_cache_checker
	import lkv_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [63:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [4:0]  cfg_data,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic found;
		val_t read_value;
	} reply_t;

	// private copy of the cache and its capacity register
	cap_t        capacity_q;
	logic        slot_used [ENTRIES];
	key_t        slot_key  [ENTRIES];
	val_t        slot_val  [ENTRIES];
	int unsigned slot_age  [ENTRIES];
	int unsigned used_count;

	reply_t replies_due[$];
	int     errors  = 0;
	int     waiting = 0;

	assign fail_count = errors;
	assign pending    = waiting;

	// slot s becomes most recent; younger slots age by one
	task automatic promote(input int s);
		int unsigned r;
		r = slot_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && i != s && slot_age[i] < r)
				slot_age[i]++;
		slot_age[s] = 0;
	endtask

	task automatic cache_access(input logic mode, input key_t k, input val_t v,
			output reply_t rep);
		int          hit;
		int          slot;
		int unsigned eff;
		int unsigned oldest;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && slot_used[i] && slot_key[i] == k)
				hit = i;
		rep.found      = (hit >= 0);
		rep.read_value = '0;
		if (mode == MODE_LOOKUP) begin
			if (hit >= 0) begin
				rep.read_value = slot_val[hit];
				promote(hit);
			end
			return;
		end
		if (hit >= 0) begin
			slot = hit;
			promote(slot);
		end else begin
			eff = capacity_q;
			if (eff < 1) eff = 1;
			if (eff > ENTRIES) eff = ENTRIES;
			slot = -1;
			if (used_count < eff)
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !slot_used[i])
						slot = i;
			if (slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i])
						slot_age[i]++;
				slot_used[slot] = 1'b1;
				slot_age[slot]  = 0;
				used_count++;
			end else begin
				// evict: oldest valid slot, lowest index on a tie
				slot   = 0;
				oldest = 0;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i] && (slot_age[i] > oldest || i == 0 ||
							!slot_used[slot])) begin
						if (!slot_used[slot] || slot_age[i] > oldest || i == slot) begin
							slot   = i;
							oldest = slot_age[i];
						end
					end
				promote(slot);
			end
			slot_key[slot] = k;
		end
		slot_val[slot] = v;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t rep;
		if (!arst_n) begin
			capacity_q = CAP_RESET;
			used_count = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_key[i]  = '0;
				slot_val[i]  = '0;
				slot_age[i]  = 0;
			end
			replies_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					$error("result item with none outstanding: found %0b, read_value %0d",
						m_tuser, $signed(m_tdata));
					errors++;
				end else begin
					rep = replies_due.pop_front();
					if (m_tuser !== rep.found) begin
						$error("found: expected %0b, actual %0b", rep.found, m_tuser);
						errors++;
					end
					if (m_tdata !== rep.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							rep.read_value, $signed(m_tdata));
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				capacity_q = cfg_data;
			if (s_tvalid && s_tready) begin
				cache_access(s_tuser, s_tdata[31:0], s_tdata[63:32], rep);
				replies_due.push_back(rep);
			end
		end
		waiting = replies_due.size();
	end

endmodule

/* tb/sv/lru_key_value_cache_top_tb.sv */
`timescale 1ns / 100ps

module lru_key_value_cache_top_tb;
	import lkv_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 125;
	localparam int POOL_MAX    = 24;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tuser   = MODE_LOOKUP;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data  = '0;

	int fail_count;
	int pending;
	int quiet_cycles = 0;
	int hold_left    = 0;
	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;

	key_t key_pool[POOL_MAX];

	always #6 clk = ~clk;

	lru_key_value_cache_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lru_key_value_cache_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_stalls_on && $urandom_range(0, 99) < 30)
				hold_left = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// called and returns at a falling edge; valid stays up for a back-to-back item
	task automatic send_item(input logic mode, input key_t k, input val_t v);
		int gap;
		gap = tx_gaps_on ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {v, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_capacity(input cap_t c);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= c;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		cap_t phase_cap[PHASES];
		int   eff;
		int   pool_n;
		logic mode;
		key_t k;
		val_t v;
		phase_cap = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd1, 5'd8, 5'd2};
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_MAX; i++)
			key_pool[i] = $urandom;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_capacity(5'd16);
		// lookup on an empty cache; value field must be ignored
		send_item(MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(MODE_STORE,  32'h0000_0000, 32'h8000_0000);
		send_item(MODE_STORE,  32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
		// update of an existing key, then read back a stored -1
		send_item(MODE_STORE,  32'h0000_0000, 32'hFFFF_FFFF);
		send_item(MODE_LOOKUP, 32'h0000_0000, 32'h0);
		send_item(MODE_LOOKUP, 32'h1234_5678, 32'h0);
		// fill every slot, then force an eviction of the least recent entry
		for (int i = 1; i <= 14; i++)
			send_item(MODE_STORE, key_t'(i), val_t'(i * 3));
		send_item(MODE_STORE,  32'h0000_0100, 32'h5555_AAAA);
		send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_item(MODE_LOOKUP, 32'h0000_0001, 32'h0);

		// later phases lower the capacity below occupancy; 0 and 31 are clamped
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(phase_cap[p]);
			tx_gaps_on   = (p % 3 != 2);
			rx_stalls_on = (p % 4 != 3);
			eff = phase_cap[p];
			if (eff < 1) eff = 1;
			if (eff > ENTRIES) eff = ENTRIES;
			pool_n = eff + 4;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				mode = $urandom_range(0, 1) ? MODE_STORE : MODE_LOOKUP;
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_n - 1)];
				else
					k = $urandom;
				case ($urandom_range(0, 19))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0000_0000;
					default: v = $urandom;
				endcase
				send_item(mode, k, v);
			end
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_match.sv
hw/rtl/lkv_store.sv
hw/rtl/lru_key_value_cache_top.sv
tb/sv/lru_key_value_cache_checker.sv
tb/sv/lru_key_value_cache_top_tb.sv
